// ===== rtl/tagged_block_token_encoder_unit_assert.svh =====
// Assertion macros shared by the encoder checkers.
`ifndef TAGGED_BLOCK_TOKEN_ENCODER_UNIT_ASSERT_SVH
`define TAGGED_BLOCK_TOKEN_ENCODER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent; uses clk and rst_n in scope.
`define TBTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TBTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

`endif

// ===== rtl/tbte_pkg.sv =====
// Shared constants, kind codes and the power-of-ten table for the token encoder.
`timescale 1ns / 1ps

package tbte_pkg;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_TIME   = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_RAW    = 3'd4;

    localparam logic [2:0] TYPE_BLOB  = 3'd5;
    localparam logic [2:0] TYPE_UDATA = 3'd6;
    localparam logic [7:0] BYTE_CLOSE = 8'h00;
    localparam logic [3:0] ASCII_HI   = 4'h3;

    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
    localparam logic [31:0] FRAC_HALF  = 32'd195312;
    localparam logic [31:0] FRAC_DIV   = 32'd390625;
    localparam logic [31:0] DIV_FIVE   = 32'd5;

    // reciprocals: x/5 = (x*RECIP_FIVE)>>34 for x < 2^32,
    // x/390625 = (x*RECIP_FRAC)>>50 for x < 2^31
    localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_FRAC = 32'd2882303762;

    // 10^i for i = 0..9; zero elsewhere
    function automatic logic [31:0] pow10(input logic [3:0] i);
        logic [31:0] r;
        case (i)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tagged_block_token_encoder_unit.sv =====
// Tagged binary format token encoder: one token in, a burst of bytes out.
`timescale 1ns / 1ps

// One token beat in, one to eleven byte beats out, last set on the final byte of each token.
// Headers carry 7 value bits per leading byte (most significant first) and a final byte with
// bit 7 set, 4 value bits and the 3-bit type. Numbers go out as a UDATA header with the digit
// count and ASCII decimal digits; timestamps as a BLOB header, the 0..5 byte big-endian
// seconds>>4 and a 16-bit word of 4 second bits and a rounded 12-bit fraction. Closers emit
// 0x00, raw tokens pass the low byte, kinds 5..7 are taken and emit nothing.
// The block takes one token at a time; token_stall is high from accept until the last byte
// has been loaded into the output register, which may still be waiting when the next token is
// taken. A header skips its leading all-zero groups, then emits the groups and the final byte.
// A number counts its digits, emits the header, then finds each digit by subtracting its power
// of ten with the shared 33-bit compare/subtract unit and emits it. A timestamp takes
// nanoseconds mod 1e9, divides by 5, scales by 8 plus the rounding half, divides by 390625,
// then skips leading zero seconds bytes and emits the header, seconds and fraction word.
// The fraction uses one shared 32x32 multiplier for two reciprocal multiplications (by 1/5,
// then by 1/390625). Closers and raw tokens emit one byte; kinds 5..7 leave the block idle.
// A stalled output register holds back every state that has a byte ready.
module tagged_block_token_encoder_unit
    import tbte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // token channel
    input  logic        token_valid,
    output logic        token_stall,
    input  logic [2:0]  kind,
    input  logic [63:0] value,
    input  logic [2:0]  type_code,
    input  logic [29:0] nanoseconds,
    // byte channel
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_H_SKIP,   // drop leading all-zero 7-bit groups
        S_H_EMIT,   // header groups, then final header byte
        S_N_CNT,    // count decimal digits
        S_N_HDR,    // UDATA header byte
        S_N_DIG,    // subtract powers of ten, emit each digit
        S_T_MOD,    // nanoseconds mod 1e9
        S_T_DIV5,   // divide by 5, reciprocal multiply
        S_T_PREP,   // times 8 plus rounding half
        S_T_DIV,    // divide by 390625, reciprocal multiply
        S_T_SKIP,   // find seconds byte count
        S_T_HDR,    // BLOB header byte
        S_T_BODY,   // seconds bytes
        S_T_W1,     // fraction word high byte
        S_T_W2,     // fraction word low byte
        S_ONE       // closer or raw byte
    } state_t;

    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;

    // datapath
    logic [63:0] sh_reg, sh_next;       // shift register for groups/bytes
    logic [31:0] acc_reg, acc_next;     // dividend / quotient
    logic [31:0] rem_reg, rem_next;     // number residue
    logic [3:0]  idx_reg, idx_next;     // group count or power index
    logic [3:0]  dig_reg, dig_next;     // current decimal digit
    logic [3:0]  lo4_reg, lo4_next;
    logic [2:0]  type_reg, type_next;
    logic        force_reg, force_next; // seconds need the full five bytes

    // shared compare/subtract unit
    logic [31:0] ua, ub;
    logic [32:0] udiff;
    logic        uge;

    // shared reciprocal multiplier
    logic [31:0] mb;
    logic [63:0] mprod;

    logic        can_put, emit, put, emit_last;
    logic [7:0]  emit_byte;
    logic [15:0] word;

    assign can_put = !out_valid_reg || !byte_stall;
    assign put     = emit && can_put;
    assign word    = {lo4_reg, 12'd0} + {3'd0, acc_reg[12:0]};

    assign mb      = (state_reg == S_T_DIV) ? RECIP_FRAC : RECIP_FIVE;
    assign mprod   = {32'd0, acc_reg} * {32'd0, mb};

    always_comb
    begin
        ua = rem_reg;
        ub = pow10(idx_reg);
        case (state_reg)
            S_T_MOD:
            begin
                ua = acc_reg;
                ub = NS_PER_SEC;
            end
            S_N_CNT:
            begin
                ub = pow10(idx_reg + 4'd1);
            end
            default:
            begin
                ub = pow10(idx_reg);
            end
        endcase
        udiff = {1'b0, ua} - {1'b0, ub};
        uge   = !udiff[32];
    end

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        lo4_next   = lo4_reg;
        type_next  = type_reg;
        force_next = force_reg;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        emit_last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (token_valid)
                begin
                    lo4_next  = value[3:0];
                    type_next = type_code;
                    unique case (kind)
                        KIND_HEADER:
                        begin
                            sh_next    = {4'd0, value[63:4]};
                            idx_next   = 4'd9;
                            state_next = S_H_SKIP;
                        end
                        KIND_NUMBER:
                        begin
                            rem_next   = value[31:0];
                            idx_next   = 4'd0;
                            state_next = S_N_CNT;
                        end
                        KIND_TIME:
                        begin
                            acc_next   = {2'd0, nanoseconds};
                            rem_next   = 32'd0;
                            sh_next    = {value[43:4], 24'd0};
                            force_next = |value[63:44];
                            idx_next   = 4'd5;
                            state_next = S_T_MOD;
                        end
                        KIND_CLOSE:
                        begin
                            sh_next    = {56'd0, BYTE_CLOSE};
                            state_next = S_ONE;
                        end
                        KIND_RAW:
                        begin
                            sh_next    = {56'd0, value[7:0]};
                            state_next = S_ONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_H_SKIP:
            begin
                if (idx_reg != 4'd0 && sh_reg[62:56] == 7'd0)
                begin
                    sh_next  = {sh_reg[56:0], 7'd0};
                    idx_next = idx_reg - 4'd1;
                end
                else
                begin
                    state_next = S_H_EMIT;
                end
            end

            S_H_EMIT:
            begin
                emit = 1'b1;
                if (idx_reg != 4'd0)
                begin
                    emit_byte = {1'b0, sh_reg[62:56]};
                    if (can_put)
                    begin
                        sh_next  = {sh_reg[56:0], 7'd0};
                        idx_next = idx_reg - 4'd1;
                    end
                end
                else
                begin
                    emit_byte = {1'b1, lo4_reg, type_reg};
                    emit_last = 1'b1;
                    if (can_put)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_N_CNT:
            begin
                if (idx_reg != 4'd9 && uge)
                begin
                    idx_next = idx_reg + 4'd1;
                end
                else
                begin
                    state_next = S_N_HDR;
                end
            end

            S_N_HDR:
            begin
                emit      = 1'b1;
                emit_byte = {1'b1, idx_reg + 4'd1, TYPE_UDATA};
                if (can_put)
                begin
                    dig_next   = 4'd0;
                    state_next = S_N_DIG;
                end
            end

            S_N_DIG:
            begin
                if (uge)
                begin
                    rem_next = udiff[31:0];
                    dig_next = dig_reg + 4'd1;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_byte = {ASCII_HI, dig_reg};
                    emit_last = (idx_reg == 4'd0);
                    if (can_put)
                    begin
                        dig_next = 4'd0;
                        if (idx_reg == 4'd0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 4'd1;
                        end
                    end
                end
            end

            S_T_MOD:
            begin
                if (uge)
                begin
                    acc_next = udiff[31:0];
                end
                state_next = S_T_DIV5;
            end

            S_T_DIV5:
            begin
                acc_next   = {2'd0, mprod[63:34]};
                state_next = S_T_PREP;
            end

            S_T_PREP:
            begin
                acc_next   = {acc_reg[28:0], 3'd0} + FRAC_HALF;
                state_next = S_T_DIV;
            end

            S_T_DIV:
            begin
                acc_next   = {18'd0, mprod[63:50]};
                state_next = S_T_SKIP;
            end

            S_T_SKIP:
            begin
                if (idx_reg != 4'd0 && !force_reg && sh_reg[63:56] == 8'd0)
                begin
                    sh_next  = {sh_reg[55:0], 8'd0};
                    idx_next = idx_reg - 4'd1;
                end
                else
                begin
                    state_next = S_T_HDR;
                end
            end

            S_T_HDR:
            begin
                emit      = 1'b1;
                emit_byte = {1'b1, {1'b0, idx_reg[2:0]} + 4'd2, TYPE_BLOB};
                if (can_put)
                begin
                    state_next = S_T_BODY;
                end
            end

            S_T_BODY:
            begin
                if (idx_reg != 4'd0)
                begin
                    emit      = 1'b1;
                    emit_byte = sh_reg[63:56];
                    if (can_put)
                    begin
                        sh_next  = {sh_reg[55:0], 8'd0};
                        idx_next = idx_reg - 4'd1;
                    end
                end
                else
                begin
                    state_next = S_T_W1;
                end
            end

            S_T_W1:
            begin
                emit      = 1'b1;
                emit_byte = word[15:8];
                if (can_put)
                begin
                    state_next = S_T_W2;
                end
            end

            S_T_W2:
            begin
                emit      = 1'b1;
                emit_byte = word[7:0];
                emit_last = 1'b1;
                if (can_put)
                begin
                    state_next = S_IDLE;
                end
            end

            S_ONE:
            begin
                emit      = 1'b1;
                emit_byte = sh_reg[7:0];
                emit_last = 1'b1;
                if (can_put)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: load on put, drain when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (put)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            last_next      = emit_last;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        dig_reg   <= dig_next;
        lo4_reg   <= lo4_next;
        type_reg  <= type_next;
        force_reg <= force_next;
    end

    assign token_stall = (state_reg != S_IDLE);
    assign byte_valid  = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/tbte_checker.sv =====
// Port-level checker for the token encoder, bound to the top level.
`timescale 1ns / 1ps
`include "tagged_block_token_encoder_unit_assert.svh"

module tbte_checker
    import tbte_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        token_valid,
    input logic        token_stall,
    input logic [2:0]  kind,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  out_byte,
    input logic        last
);

    logic tok_take;
    logic byte_wait;

    assign tok_take  = token_valid && !token_stall;
    assign byte_wait = byte_valid && byte_stall;

    // stalled byte beat holds
    `TBTE_ASSERT_NXT(a_byte_hold, byte_wait, byte_valid && $stable(out_byte) && $stable(last))
    // a token that emits bytes keeps the block busy
    `TBTE_ASSERT_NXT(a_busy_after_take, tok_take && kind <= KIND_RAW, token_stall)
    // unused kinds are dropped without a busy period
    `TBTE_ASSERT_NXT(a_unused_drop, tok_take && kind > KIND_RAW, !token_stall)
    // while idle, only a token's final byte can wait at the output
    `TBTE_ASSERT_NOW(a_idle_last, !token_stall && byte_valid, last)
    // an idle block with an empty output produces nothing
    `TBTE_ASSERT_NXT(a_idle_quiet, !token_stall && !byte_valid, !byte_valid)

endmodule

bind tagged_block_token_encoder_unit tbte_checker u_tbte_checker (.*);
